>>> rtl/assert_macros.svh
// Assertion macros shared by the stack machine ALU modules.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> rtl/smalu_pkg.sv
// Package for the stack machine ALU: sizes, opcodes, status codes and types.
// No dependencies.
package smalu_pkg;
  localparam int STACK_DEPTH = 1024;
  localparam int NUM_REGS = 8;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int REG_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_POP = 4'd1;
  localparam logic [3:0] OP_ADD = 4'd2;
  localparam logic [3:0] OP_SUB = 4'd3;
  localparam logic [3:0] OP_MUL = 4'd4;
  localparam logic [3:0] OP_DIV = 4'd5;
  localparam logic [3:0] OP_OUT = 4'd6;
  localparam logic [3:0] OP_PUSHREG = 4'd7;
  localparam logic [3:0] OP_POPREG = 4'd8;
  localparam logic [3:0] OP_GETREG = 4'd9;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;
  localparam logic [1:0] ST_DIVZ = 2'd3;

  typedef struct packed {
    logic [3:0] func;
    logic signed [63:0] value;
    logic [2:0] reg_index;
  } instr_t;

  typedef struct packed {
    logic signed [63:0] data;
    logic data_valid;
    logic [1:0] status;
    logic [10:0] stack_count;
  } result_t;

  // Decoded instruction as it travels from the front to the back.
  typedef struct packed {
    logic [3:0] func;
    logic signed [63:0] value;
    logic [2:0] reg_index;
    logic need1;
    logic need2;
    logic grows;
    logic reg_ok;
  } cmd_t;
endpackage

>>> rtl/smalu_if.sv
// Valid/ready channel interface carrying one payload of a chosen type.
// Used with smalu_pkg types for the instruction and result channels.
interface smalu_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/smalu_front.sv
// Front end: accepts instruction beats, classifies them, and keeps a
// two-entry queue toward the back end. Depends on smalu_pkg.
module smalu_front (
  input logic clk,
  input logic rst,
  smalu_if.sink in_ch,
  output smalu_pkg::cmd_t cmd,
  output logic cmd_valid,
  input logic cmd_take
);
  import smalu_pkg::*;

  cmd_t q [2];
  logic [1:0] count;
  logic rd_ptr;
  logic wr_ptr;
  cmd_t dec;
  logic push;

  always_comb begin
    dec.func = in_ch.payload.func;
    dec.value = in_ch.payload.value;
    dec.reg_index = in_ch.payload.reg_index;
    dec.need1 = (in_ch.payload.func inside {OP_POP, OP_OUT, OP_POPREG});
    dec.need2 = (in_ch.payload.func inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV});
    dec.grows = (in_ch.payload.func inside {OP_PUSH, OP_PUSHREG, OP_ADD, OP_SUB,
                                            OP_MUL, OP_DIV});
    dec.reg_ok = ({29'd0, in_ch.payload.reg_index} < NUM_REGS);
  end

  assign in_ch.ready = (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= dec;
    if (rst) begin
      count <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, cmd_take};
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_take_valid, clk, rst, cmd_take |-> cmd_valid, "take from empty queue")
  `ASSERT_CLK(a_count_max, clk, rst, count <= 2'd2, "queue count out of range")
  `ASSERT_CLK(a_full_noready, clk, rst, (count == 2'd2) |-> !in_ch.ready,
              "ready while queue full")
endmodule

>>> rtl/smalu_div.sv
// Iterative 64-bit signed divider, one quotient bit per cycle.
// Truncates toward zero, wraps modulo 2^64. Depends on smalu_pkg.
module smalu_div (
  input logic clk,
  input logic rst,
  input logic start,
  input logic [63:0] dividend,
  input logic [63:0] divisor,
  output logic busy,
  output logic done,
  output logic [63:0] quotient
);
  import smalu_pkg::*;

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic neg;
  logic [6:0] cnt;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {1'b0, dvs};
  assign quotient = neg ? (64'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
        rem <= 64'd0;
        quo <= dividend[63] ? (64'd0 - dividend) : dividend;
        dvs <= divisor[63] ? (64'd0 - divisor) : divisor;
        neg <= dividend[63] ^ divisor[63];
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/smalu_back.sv
// Back end: executes commands against the stack memory and register file
// and drives the result channel. Depends on smalu_pkg and smalu_div.
module smalu_back (
  input logic clk,
  input logic rst,
  input smalu_pkg::cmd_t cmd,
  input logic cmd_valid,
  output logic cmd_take,
  smalu_if.source out_ch
);
  import smalu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1 = 3'd1;
  localparam logic [2:0] S_RD2 = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_MUL = 3'd4;
  localparam logic [2:0] S_DIVW = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [63:0] mem [STACK_DEPTH];
  logic [63:0] rf [NUM_REGS];
  logic [2:0] state;
  logic [SP_W-1:0] sp;
  cmd_t c;
  logic [63:0] rd_data;
  logic [63:0] a;
  logic [63:0] b;
  logic [ADDR_W-1:0] rd_addr;
  logic rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [63:0] wr_data;
  logic wr_en;
  logic [63:0] mp [3];
  logic [1:0] mstep;
  logic div_start;
  logic div_busy;
  logic div_done;
  logic [63:0] div_q;
  logic [REG_W-1:0] ridx;
  result_t res;
  logic [SP_W-1:0] sp_m1;
  logic [SP_W-1:0] sp_m2;
  logic [SP_W-1:0] sp_p1;

  assign ridx = c.reg_index[REG_W-1:0];
  assign sp_m1 = sp - SP_W'(1);
  assign sp_m2 = sp - SP_W'(2);
  assign sp_p1 = sp + SP_W'(1);
  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.payload = res;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  smalu_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(b), .divisor(a),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    rd_en = 1'b0;
    rd_addr = sp_m1[ADDR_W-1:0];
    if (state == S_IDLE && cmd_valid) begin
      rd_en = 1'b1;
      rd_addr = sp_m1[ADDR_W-1:0];
    end else if (state == S_RD1) begin
      rd_en = 1'b1;
      rd_addr = sp_m2[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    div_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      for (int i = 0; i < NUM_REGS; i++) rf[i] <= 64'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            c <= cmd;
            state <= S_RD1;
          end
        end
        S_RD1: begin
          a <= rd_data;
          state <= S_RD2;
        end
        S_RD2: begin
          b <= rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          res.data <= 64'd0;
          res.data_valid <= 1'b0;
          res.status <= ST_OK;
          res.stack_count <= 11'(sp);
          state <= S_OUT;
          if ((c.need1 && sp == '0) || (c.need2 && sp < SP_W'(2))) begin
            res.status <= ST_UNDER;
          end else if (c.grows && sp >= SP_W'(STACK_DEPTH)) begin
            res.status <= ST_OVER;
          end else begin
            case (c.func)
              OP_PUSH, OP_PUSHREG: begin
                wr_en <= 1'b1;
                wr_addr <= sp[ADDR_W-1:0];
                wr_data <= (c.func == OP_PUSH) ? c.value
                         : (c.reg_ok ? rf[ridx] : 64'd0);
                sp <= sp_p1;
                res.stack_count <= 11'(sp_p1);
              end
              OP_POP, OP_OUT, OP_POPREG: begin
                if (c.func == OP_OUT) begin
                  res.data <= a;
                  res.data_valid <= 1'b1;
                end
                if (c.func == OP_POPREG && c.reg_ok) rf[ridx] <= a;
                sp <= sp_m1;
                res.stack_count <= 11'(sp_m1);
              end
              OP_ADD, OP_SUB: begin
                wr_en <= 1'b1;
                wr_addr <= sp[ADDR_W-1:0];
                wr_data <= (c.func == OP_ADD) ? (a + b) : (b - a);
                sp <= sp_p1;
                res.stack_count <= 11'(sp_p1);
              end
              OP_MUL: begin
                mp[0] <= 64'(a[31:0] * b[31:0]);
                mp[1] <= 64'(a[63:32] * b[31:0]);
                mp[2] <= 64'(a[31:0] * b[63:32]);
                mstep <= 2'd0;
                state <= S_MUL;
              end
              OP_DIV: begin
                if (a == 64'd0) begin
                  res.status <= ST_DIVZ;
                end else begin
                  div_start <= 1'b1;
                  state <= S_DIVW;
                end
              end
              OP_GETREG: begin
                res.data <= c.reg_ok ? rf[ridx] : 64'd0;
                res.data_valid <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: begin
          // Low product plus the two cross terms shifted into the high word.
          wr_en <= 1'b1;
          wr_addr <= sp[ADDR_W-1:0];
          wr_data <= mp[0] + {mp[1][31:0] + mp[2][31:0], 32'd0};
          sp <= sp_p1;
          res.stack_count <= 11'(sp_p1);
          state <= S_OUT;
        end
        S_DIVW: begin
          if (div_done) begin
            wr_en <= 1'b1;
            wr_addr <= sp[ADDR_W-1:0];
            wr_data <= div_q;
            sp <= sp_p1;
            res.stack_count <= 11'(sp_p1);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_sp_range, clk, rst, sp <= SP_W'(STACK_DEPTH), "stack pointer overrun")
  `ASSERT_CLK(a_div_state, clk, rst, div_busy |-> (state == S_DIVW),
              "divider busy outside wait")
  `ASSERT_CLK(a_hold, clk, rst, (out_ch.valid && !out_ch.ready) |=> out_ch.valid,
              "result dropped while stalled")
  `ASSERT_CLK(a_mstep, clk, rst, (state == S_MUL) |-> (mstep == 2'd0), "multiply step")
endmodule

>>> rtl/stack_machine_alu_core.sv
// Stack machine ALU top level: instruction channel in, result channel out.
// Depends on smalu_pkg, smalu_if, smalu_front and smalu_back.
//
// Each instruction beat on in_ch (func, value, reg_index) yields exactly one
// result beat on out_ch (data, data_valid, status, stack_count), in order.
// The front end queues up to two decoded instructions, so instruction beats
// are taken while the back end works or waits on a stalled receiver.
// The back end runs one instruction at a time: two stack reads, then the
// operation. Multiply adds a step that sums split 32-bit partial products;
// divide waits on the one-bit-per-cycle divider. The back end takes the
// next instruction only after the result beat of the last one is accepted.
// The stack is a memory with separate read and write ports in the back end.
// A stalled receiver holds the result beat steady; the back end waits and
// the front queue fills, then in_ch.ready drops.
// Reset (rst, synchronous) empties the stack and the queue and zeroes the
// register file. Stack memory contents are not cleared.
module stack_machine_alu_core (
  input logic clk,
  input logic rst,
  smalu_if.sink in_ch,
  smalu_if.source out_ch
);
  import smalu_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  smalu_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_take(cmd_take)
  );

  smalu_back u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .out_ch(out_ch)
  );
endmodule

>>> bench/stack_machine_alu_core_tb.sv
// Self-checking testbench for stack_machine_alu_core: directed table, then random programs.
// Depends on smalu_pkg, smalu_if and the RTL of the block under bench.
`timescale 1ns / 1ps

module stack_machine_alu_core_tb;
  import smalu_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_BEAT = 300;
  localparam int RAND_ITEMS = 1900;

  typedef struct {
    logic [3:0] func;
    logic [63:0] value;
    logic [2:0] reg_index;
    bit typed;
    result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  smalu_if #(.T(instr_t)) in_ch (clk);
  smalu_if #(.T(result_t)) out_ch (clk);

  stack_machine_alu_core dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Shadow machine state.
  logic [63:0] shadow_stack [STACK_DEPTH];
  int unsigned shadow_sp;
  logic [63:0] shadow_regs [NUM_REGS];

  result_t pending_results [$];
  int unsigned mismatches;
  int unsigned beats_out;
  bit quiet_sender;
  bit quiet_receiver;

  function automatic logic [63:0] abs64(logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] read_reg(logic [2:0] idx);
    return (idx < NUM_REGS) ? shadow_regs[idx] : 64'd0;
  endfunction

  // Executes one instruction on the shadow state and returns its result beat.
  function automatic result_t execute_instr(instr_t ins);
    result_t r;
    logic [63:0] a, b, q;
    r = '0;
    r.status = ST_OK;
    case (ins.func)
      OP_PUSH, OP_PUSHREG: begin
        if (shadow_sp >= STACK_DEPTH) begin
          r.status = ST_OVER;
        end else begin
          shadow_stack[shadow_sp] = (ins.func == OP_PUSH) ? ins.value : read_reg(ins.reg_index);
          shadow_sp++;
        end
      end
      OP_POP, OP_OUT, OP_POPREG: begin
        if (shadow_sp < 1) begin
          r.status = ST_UNDER;
        end else begin
          a = shadow_stack[shadow_sp - 1];
          if (ins.func == OP_OUT) begin
            r.data = a;
            r.data_valid = 1'b1;
          end else if (ins.func == OP_POPREG && ins.reg_index < NUM_REGS) begin
            shadow_regs[ins.reg_index] = a;
          end
          shadow_sp--;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (shadow_sp < 2) begin
          r.status = ST_UNDER;
        end else if (shadow_sp >= STACK_DEPTH) begin
          r.status = ST_OVER;
        end else begin
          a = shadow_stack[shadow_sp - 1];
          b = shadow_stack[shadow_sp - 2];
          if (ins.func == OP_DIV && a == 64'd0) begin
            r.status = ST_DIVZ;
          end else begin
            case (ins.func)
              OP_ADD: q = a + b;
              OP_SUB: q = b - a;
              OP_MUL: q = a * b;
              default: begin
                q = abs64(b) / abs64(a);
                if (a[63] ^ b[63]) q = 64'd0 - q;
              end
            endcase
            shadow_stack[shadow_sp] = q;
            shadow_sp++;
          end
        end
      end
      OP_GETREG: begin
        r.data = read_reg(ins.reg_index);
        r.data_valid = 1'b1;
      end
      default: ;
    endcase
    r.stack_count = shadow_sp[10:0];
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 64'h7fff_ffff_ffff_ffff;
      1: return 64'h8000_0000_0000_0000;
      2: return 64'hffff_ffff_ffff_ffff;
      3: return 64'd0;
      4: return 64'($signed($urandom_range(0, 40)) - 20);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Picks an operation that mostly fits the current stack depth.
  function automatic instr_t rand_instr(bit grow);
    instr_t ins;
    int unsigned pick;
    ins.value = rand_word();
    ins.reg_index = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 4) ins.func = 4'($urandom_range(10, 15));
    else if (pick < 10) ins.func = 4'($urandom_range(0, 9));
    else if (shadow_sp < 2 || (grow && pick < 50)) ins.func = (pick & 1) ? OP_PUSH : OP_PUSHREG;
    else if (pick < 30) ins.func = OP_PUSH;
    else ins.func = 4'($urandom_range(1, 9));
    return ins;
  endfunction

  task automatic send_instr(instr_t ins, bit typed, result_t typed_res);
    result_t pred;
    int unsigned gap;
    in_ch.payload <= ins;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = execute_instr(ins);
    pending_results.push_back(typed ? typed_res : pred);
    gap = quiet_sender ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic result_t mk(logic [63:0] d, bit v, logic [1:0] st, int cnt);
    result_t r;
    r.data = d;
    r.data_valid = v;
    r.status = st;
    r.stack_count = 11'(cnt);
    return r;
  endfunction

  // Receiver: random stalls, one long hold-off while the sender keeps going.
  initial begin
    int unsigned stall;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && beats_out >= HOLD_AT_BEAT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = quiet_receiver ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      beats_out <= beats_out + 1;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", out_ch.payload);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.payload.data !== want.data
            || out_ch.payload.data_valid !== want.data_valid
            || out_ch.payload.status !== want.status
            || out_ch.payload.stack_count !== want.stack_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected data=%h valid=%b status=%0d count=%0d,",
                      " got data=%h valid=%b status=%0d count=%0d"},
                     want.data, want.data_valid, want.status, want.stack_count,
                     out_ch.payload.data, out_ch.payload.data_valid,
                     out_ch.payload.status, out_ch.payload.stack_count);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("stack_machine_alu_core_tb: done, errors");
    $finish;
  end

  initial begin
    row_t rows [$];
    instr_t ins;
    int unsigned wait_cycles;
    mismatches = 0;
    beats_out = 0;
    shadow_sp = 0;
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = 64'd0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows = '{
      '{OP_POP, 64'd0, 3'd0, 1, mk(0, 0, ST_UNDER, 0)},
      '{OP_OUT, 64'd0, 3'd0, 1, mk(0, 0, ST_UNDER, 0)},
      '{OP_ADD, 64'd0, 3'd0, 1, mk(0, 0, ST_UNDER, 0)},
      '{OP_POPREG, 64'd0, 3'd1, 1, mk(0, 0, ST_UNDER, 0)},
      '{OP_GETREG, 64'd0, 3'd3, 1, mk(0, 1, ST_OK, 0)},
      '{OP_PUSH, 64'h7fff_ffff_ffff_ffff, 3'd0, 1, mk(0, 0, ST_OK, 1)},
      '{OP_DIV, 64'd0, 3'd0, 1, mk(0, 0, ST_UNDER, 1)},
      '{OP_PUSH, 64'd0, 3'd0, 1, mk(0, 0, ST_OK, 2)},
      '{OP_DIV, 64'd0, 3'd0, 1, mk(0, 0, ST_DIVZ, 2)},
      '{OP_PUSH, 64'h8000_0000_0000_0000, 3'd7, 1, mk(0, 0, ST_OK, 3)},
      '{OP_PUSH, 64'hffff_ffff_ffff_ffff, 3'd0, 1, mk(0, 0, ST_OK, 4)},
      // Most negative over minus one wraps back to the most negative value.
      '{OP_DIV, 64'd0, 3'd0, 1, mk(0, 0, ST_OK, 5)},
      '{OP_OUT, 64'd0, 3'd0, 1, mk(64'h8000_0000_0000_0000, 1, ST_OK, 4)},
      '{OP_ADD, 64'd0, 3'd0, 0, '0},
      '{OP_SUB, 64'd0, 3'd0, 0, '0},
      '{OP_MUL, 64'd0, 3'd0, 0, '0},
      '{4'd15, 64'd0, 3'd0, 1, mk(0, 0, ST_OK, 7)},
      '{4'd10, 64'd0, 3'd0, 1, mk(0, 0, ST_OK, 7)},
      '{OP_PUSHREG, 64'd0, 3'd7, 1, mk(0, 0, ST_OK, 8)},
      '{OP_POP, 64'd0, 3'd0, 1, mk(0, 0, ST_OK, 7)},
      '{OP_POPREG, 64'd0, 3'd2, 0, '0},
      '{OP_GETREG, 64'd0, 3'd2, 0, '0},
      '{OP_PUSHREG, 64'd0, 3'd2, 0, '0},
      '{OP_MUL, 64'd0, 3'd0, 0, '0},
      '{OP_OUT, 64'd0, 3'd0, 0, '0}
    };
    foreach (rows[i]) begin
      ins.func = rows[i].func;
      ins.value = rows[i].value;
      ins.reg_index = rows[i].reg_index;
      send_instr(ins, rows[i].typed, rows[i].res);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 150 == 0) begin
        quiet_sender = ($urandom_range(0, 3) == 0);
        quiet_receiver = ($urandom_range(0, 3) == 0);
      end
      // One stretch drives the stack to full and tries every growing operation there.
      if (n >= 600 && n < 1700) begin
        if (shadow_sp < STACK_DEPTH) begin
          ins = rand_instr(1'b1);
          if ($urandom_range(0, 3) != 0) ins.func = OP_PUSH;
        end else begin
          ins = rand_instr(1'b0);
          ins.func = 4'($urandom_range(0, 9));
        end
      end else begin
        ins = rand_instr(shadow_sp < 4);
      end
      send_instr(ins, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("stack_machine_alu_core_tb: done, clean");
    end else begin
      $display("stack_machine_alu_core_tb: done, errors");
    end
    $finish;
  end
endmodule
